// ===== src/amp_pkg.sv =====
// Shared types, constants and register codes for the address pattern matcher.
package amp_pkg;

    localparam int MAX_PATTERN  = 20;
    localparam int LOADED_CHARS = 20;
    localparam int CHAR_W       = 8;
    localparam int LEN_REG_W    = 5;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ADDR_W   = 3;
    localparam int LEN_W        = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W        = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int POS_W        = $clog2(MAX_PATTERN + 2);
    localparam int POS_SAT      = MAX_PATTERN + 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MATCH_MODE  = 3'd0,
        CFG_PAT_LEN     = 3'd1,
        CFG_CHARS_LOW   = 3'd2,
        CFG_CHARS_MID   = 3'd3,
        CFG_CHARS_HIGH  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_SUFFIX   = 2'd0,
        MODE_PREFIX   = 2'd1,
        MODE_CONTAINS = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0]                          mode;
        logic [LEN_W-1:0]                    len;
        logic [MAX_PATTERN-1:0][CHAR_W-1:0]  pat;
    } t_cfg;

endpackage

// ===== src/amp_cfg_regs.sv =====
// Configuration registers and the decoded pattern view for the matcher.
module amp_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [amp_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [amp_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    output amp_pkg::t_cfg                        o_cfg
);

    logic [1:0]                      r_mode;
    logic [amp_pkg::LEN_REG_W-1:0]   r_len;
    logic [63:0]                     r_chars_low;
    logic [63:0]                     r_chars_mid;
    logic [31:0]                     r_chars_high;
    logic [8*amp_pkg::LOADED_CHARS-1:0] flat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 2'd0;
            r_len        <= amp_pkg::LEN_REG_W'(1);
            r_chars_low  <= '0;
            r_chars_mid  <= '0;
            r_chars_high <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                amp_pkg::CFG_MATCH_MODE: r_mode       <= i_cfg_wdata[1:0];
                amp_pkg::CFG_PAT_LEN:    r_len        <= i_cfg_wdata[amp_pkg::LEN_REG_W-1:0];
                amp_pkg::CFG_CHARS_LOW:  r_chars_low  <= i_cfg_wdata;
                amp_pkg::CFG_CHARS_MID:  r_chars_mid  <= i_cfg_wdata;
                amp_pkg::CFG_CHARS_HIGH: r_chars_high <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    assign flat       = {r_chars_high, r_chars_mid, r_chars_low};
    assign o_cfg.mode = r_mode;

    // Saturate the length to the pattern store depth.
    assign o_cfg.len = (int'(r_len) > amp_pkg::MAX_PATTERN)
                     ? amp_pkg::LEN_W'(amp_pkg::MAX_PATTERN)
                     : amp_pkg::LEN_W'(r_len);

    // Characters beyond the loaded registers read as zero.
    for (genvar j = 0; j < amp_pkg::MAX_PATTERN; j++) begin : g_pat
        if (j < amp_pkg::LOADED_CHARS) begin : g_loaded
            assign o_cfg.pat[j] = flat[8*j +: 8];
        end else begin : g_unloaded
            assign o_cfg.pat[j] = '0;
        end
    end

endmodule

// ===== src/amp_core.sv =====
// Per-character match state: partial-match vector, position, prefix and found flags.
module amp_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [amp_pkg::CHAR_W-1:0]    i_char,
    input  logic                          i_last,
    input  amp_pkg::t_cfg                 i_cfg,
    output logic                          o_matched
);

    logic [amp_pkg::MAX_PATTERN-1:0] r_prog;
    logic [amp_pkg::MAX_PATTERN-1:0] n_prog;
    logic [amp_pkg::MAX_PATTERN-1:0] eq;
    logic [amp_pkg::POS_W-1:0]       r_pos;
    logic [amp_pkg::POS_W-1:0]       n_pos;
    logic                            r_prefix_ok;
    logic                            n_prefix_ok;
    logic                            r_found;
    logic                            n_found;
    logic [amp_pkg::LEN_W-1:0]       len_m1;
    logic [amp_pkg::POS_W-1:0]       pos_m1;
    logic [amp_pkg::POS_W-1:0]       len_ext;
    logic                            len_ok;
    logic                            hit;
    logic                            in_prefix;

    // Bit j: pattern characters 0..j end at this character.
    for (genvar j = 0; j < amp_pkg::MAX_PATTERN; j++) begin : g_eq
        assign eq[j] = (i_char == i_cfg.pat[j]);
        if (j == 0) begin : g_first
            assign n_prog[j] = eq[j];
        end else begin : g_rest
            assign n_prog[j] = r_prog[j-1] & eq[j];
        end
    end

    always_comb begin
        len_ok    = (i_cfg.len != '0);
        len_m1    = i_cfg.len - amp_pkg::LEN_W'(1);
        len_ext   = amp_pkg::POS_W'(i_cfg.len);
        pos_m1    = r_pos - amp_pkg::POS_W'(1);
        hit       = len_ok && n_prog[len_m1[amp_pkg::IDX_W-1:0]];
        in_prefix = (r_pos != '0) && (r_pos <= len_ext);

        n_prefix_ok = r_prefix_ok;
        if (in_prefix && (i_char != i_cfg.pat[pos_m1[amp_pkg::IDX_W-1:0]])) begin
            n_prefix_ok = 1'b0;
        end
        n_found = r_found | hit;
        n_pos   = (r_pos == amp_pkg::POS_W'(amp_pkg::POS_SAT)) ? r_pos
                                                              : r_pos + amp_pkg::POS_W'(1);

        case (i_cfg.mode)
            amp_pkg::MODE_SUFFIX:   o_matched = hit;
            amp_pkg::MODE_PREFIX:   o_matched = len_ok && n_prefix_ok && (r_pos >= len_ext);
            amp_pkg::MODE_CONTAINS: o_matched = len_ok && n_found;
            default:                o_matched = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog      <= '0;
            r_pos       <= '0;
            r_prefix_ok <= 1'b1;
            r_found     <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_prog      <= '0;
                r_pos       <= '0;
                r_prefix_ok <= 1'b1;
                r_found     <= 1'b0;
            end else begin
                r_prog      <= n_prog;
                r_pos       <= n_pos;
                r_prefix_ok <= n_prefix_ok;
                r_found     <= n_found;
            end
        end
    end

endmodule

// ===== src/address_pattern_matcher_top.sv =====
// Top level of the address pattern matcher: stream ports, input and result registers.
//
// Streams an address one character per item (tlast on the final character) and
// returns one item per address, bit 0 set when the address fits the configured
// pattern: suffix mode compares the final characters, prefix mode the characters
// after the first, contains mode looks for the pattern anywhere. The block takes
// one item per cycle, but the last character of an address waits in the input
// register until the result register is free; the combinational compare then
// loads the result register from it. A stalled result holds back only the last
// character of the next address. Each character is compared against all pattern
// characters at once and a partial-match vector advances by one bit, so there is
// no loop to wait on. Configuration is to be written through i_cfg_wr_en /
// i_cfg_addr / i_cfg_wdata while no address is in flight; the block itself does
// not enforce this.
module address_pattern_matcher_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,   // [7:0] char_code
    input  logic                              i_s_axis_tlast,   // last_char
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [7:0]                        o_m_axis_tdata,   // [0] matched, [7:1] zero
    // configuration
    input  logic                              i_cfg_wr_en,
    input  logic [amp_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [amp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    amp_pkg::t_cfg                  cfg;
    logic                           r_in_valid;
    logic [amp_pkg::CHAR_W-1:0]     r_in_char;
    logic                           r_in_last;
    logic                           r_out_valid;
    logic                           r_out_matched;
    logic                           out_free;
    logic                           step;
    logic                           matched;

    amp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    amp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_char    (r_in_char),
        .i_last    (r_in_last),
        .i_cfg     (cfg),
        .o_matched (matched)
    );

    // Advance a held character unless it ends an address and the result slot is busy.
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && (!r_in_last || out_free);
    assign o_s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload: load on every accepted item, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_char <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // Result register: fill on the last character, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out_matched <= matched;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_matched};

endmodule

// ===== src/amp_checker.sv =====
// Port-level checks for the address pattern matcher, bound to the top level.
module amp_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_s_axis_tready,
    input  logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [7:0]                        o_m_axis_tdata
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // Reset empties the result slot.
    a_out_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // Reset leaves the input side ready for a new address.
    a_in_ready_reset: assert property (@(posedge i_clk) !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready after reset");

    // Only the match flag may be set in a result.
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[7:1] == 7'd0))
        else $error("result padding bits set");

endmodule

bind address_pattern_matcher_top amp_checker u_amp_checker (.*);

// ===== sim/address_pattern_checker.sv =====
// Checker for the address pattern matcher: predicts each result and compares it.
`timescale 1ns / 1ps

module address_pattern_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    input  logic [7:0]                          i_s_tdata,    // [7:0] char_code
    input  logic                                i_s_tlast,    // last_char
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [7:0]                          i_m_tdata,    // [0] matched, [7:1] zero
    input  logic                                i_cfg_wr_en,
    input  logic [amp_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [amp_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    output int                                  o_mismatch_count,
    output int                                  o_results_due
);

    typedef logic [amp_pkg::CHAR_W-1:0] t_char;

    // register copies
    logic [1:0]                    mode_q;
    logic [amp_pkg::LEN_REG_W-1:0] len_q;
    logic [63:0]                   chars_low_q;
    logic [63:0]                   chars_mid_q;
    logic [31:0]                   chars_high_q;

    // per-address state
    t_char                window_q [amp_pkg::MAX_PATTERN];
    int                   seen_q;
    bit                   prefix_ok_q;
    bit                   found_q;

    bit                   matched_due [$];

    function automatic t_char pattern_byte(input int j);
        if (j < 8)  return chars_low_q[8*j +: 8];
        if (j < 16) return chars_mid_q[8*(j-8) +: 8];
        if (j < 20) return chars_high_q[8*(j-16) +: 8];
        return '0;
    endfunction

    function automatic bit window_ends_in_pattern(input int plen, input int count);
        if (plen == 0 || count < plen) return 1'b0;
        for (int j = 0; j < plen; j++) begin
            if (window_q[plen-1-j] != pattern_byte(j)) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_address_state();
        foreach (window_q[k]) window_q[k] = '0;
        seen_q      = 0;
        prefix_ok_q = 1'b1;
        found_q     = 1'b0;
    endtask

    task automatic advance_match_state(input t_char c, input bit last);
        int plen;
        int pos;
        bit hit;
        bit m;
        plen = (len_q > amp_pkg::MAX_PATTERN) ? amp_pkg::MAX_PATTERN : int'(len_q);
        pos  = seen_q;
        if (pos >= 1 && pos <= plen && c != pattern_byte(pos-1)) prefix_ok_q = 1'b0;
        for (int k = amp_pkg::MAX_PATTERN-1; k > 0; k--) window_q[k] = window_q[k-1];
        window_q[0] = c;
        seen_q = (pos < 255) ? pos + 1 : 255;
        hit = window_ends_in_pattern(plen, seen_q);
        if (hit) found_q = 1'b1;
        if (last) begin
            m = 1'b0;
            if (plen != 0) begin
                if (mode_q == amp_pkg::MODE_SUFFIX)        m = hit;
                else if (mode_q == amp_pkg::MODE_PREFIX)   m = prefix_ok_q && (seen_q >= plen + 1);
                else if (mode_q == amp_pkg::MODE_CONTAINS) m = found_q;
            end
            matched_due = {matched_due, m};
            clear_address_state();
        end
    endtask

    always @(posedge i_clk) begin
        bit want;
        if (!i_rst_n) begin
            mode_q       = amp_pkg::MODE_SUFFIX;
            len_q        = amp_pkg::LEN_REG_W'(1);
            chars_low_q  = '0;
            chars_mid_q  = '0;
            chars_high_q = '0;
            clear_address_state();
            matched_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    amp_pkg::CFG_MATCH_MODE: mode_q       = i_cfg_wdata[1:0];
                    amp_pkg::CFG_PAT_LEN:    len_q        = i_cfg_wdata[amp_pkg::LEN_REG_W-1:0];
                    amp_pkg::CFG_CHARS_LOW:  chars_low_q  = i_cfg_wdata;
                    amp_pkg::CFG_CHARS_MID:  chars_mid_q  = i_cfg_wdata;
                    amp_pkg::CFG_CHARS_HIGH: chars_high_q = i_cfg_wdata[31:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) advance_match_state(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                if (matched_due.size() == 0) begin
                    $error("unexpected result item, matched = %0d", i_m_tdata[0]);
                    o_mismatch_count++;
                end else begin
                    want = matched_due.pop_front();
                    if (i_m_tdata[0] !== want) begin
                        $error("matched: expected %0d, got %0d", want, i_m_tdata[0]);
                        o_mismatch_count++;
                    end
                    if (i_m_tdata[7:1] !== 7'd0) begin
                        $error("padding: expected 0, got %0h", i_m_tdata[7:1]);
                        o_mismatch_count++;
                    end
                end
            end
        end
        o_results_due = matched_due.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the address pattern matcher: stimulus, pressure phases and verdict.
`timescale 1ns / 1ps

module tb_top;

    typedef logic [amp_pkg::CHAR_W-1:0] t_char;

    localparam int ITEMS_PER_SETUP = 90;     // random characters per pattern setup
    localparam int SETUPS_PER_MIX  = 3;      // pattern setups per pressure mix
    localparam int PRESSURE_MIXES  = 4;
    localparam int LONG_ADDRESS    = 300;    // pushes the character count past saturation
    localparam int SETTLE_CYCLES   = 4;      // input and result registers, with margin
    localparam int WATCHDOG_LIMIT  = 5000;

    localparam logic [1:0]                     MODE_UNUSED   = 2'd3;
    localparam logic [amp_pkg::CFG_ADDR_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [amp_pkg::CFG_ADDR_W-1:0] CFG_UNUSED_HI = 3'd7;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = '0;
    logic                           s_tlast   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [7:0]                     m_tdata;
    logic                           cfg_wr_en = 1'b0;
    logic [amp_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [amp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatch_count;
    int results_due;

    // pressure knobs, in percent
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // current pattern setup, kept for shaping the stimulus
    logic [1:0] mode_sel;
    int         len_sel;
    t_char      pat_sel [amp_pkg::MAX_PATTERN];

    t_char address_q [$];
    int    items_sent     = 0;
    int    addresses_sent = 0;
    int    setups_loaded  = 0;
    int    idle_cycles    = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    address_pattern_matcher_top DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    address_pattern_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_s_tlast        (s_tlast),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_addr       (cfg_addr),
        .i_cfg_wdata      (cfg_wdata),
        .o_mismatch_count (mismatch_count),
        .o_results_due    (results_due)
    );

    // Receiver: stall at random at the current pressure.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run when nothing moves on either stream for too long.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Write one register; hold the enable for a single edge, then drop it again.
    task automatic write_reg(input logic [amp_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [amp_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, wait until every result has come back, then let the pipeline drain.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (results_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Load mode, length and all twenty pattern characters. Unused upper bits of the
    // write data carry random values, which the block must ignore.
    task automatic load_pattern(input logic [1:0] mode, input int plen);
        logic [63:0] low;
        logic [63:0] mid;
        logic [63:0] high;
        for (int j = 0; j < 8; j++) begin
            low[8*j +: 8] = pat_sel[j];
            mid[8*j +: 8] = pat_sel[j+8];
        end
        high = {$urandom, 32'd0};
        for (int j = 0; j < 4; j++) high[8*j +: 8] = pat_sel[j+16];
        mode_sel = mode;
        len_sel  = plen;
        write_reg(amp_pkg::CFG_MATCH_MODE, {$urandom, 30'($urandom), mode});
        write_reg(amp_pkg::CFG_PAT_LEN,
                  {$urandom, 27'($urandom), amp_pkg::LEN_REG_W'(plen)});
        write_reg(amp_pkg::CFG_CHARS_LOW, low);
        write_reg(amp_pkg::CFG_CHARS_MID, mid);
        write_reg(amp_pkg::CFG_CHARS_HIGH, high);
        setups_loaded++;
    endtask

    // Offer one item; the ready seen at the falling edge decides the next rising edge.
    task automatic send_item(input t_char c, input bit last);
        bit ready_seen;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do begin
            @(negedge clk);
            ready_seen = s_tready;
            @(posedge clk);
        end while (!ready_seen);
        items_sent++;
    endtask

    task automatic send_address();
        foreach (address_q[i]) send_item(address_q[i], i == address_q.size() - 1);
        addresses_sent++;
    endtask

    // Build a random address. Most carry the pattern where the mode looks for it,
    // some with one bit flipped in it; the rest are noise over a mixed alphabet.
    task automatic make_address(input bit long_one);
        int plen;
        int total;
        int pos;
        int r;
        address_q.delete();
        plen  = (len_sel > amp_pkg::MAX_PATTERN) ? amp_pkg::MAX_PATTERN : len_sel;
        total = long_one ? LONG_ADDRESS : $urandom_range(1, plen + 6);
        r     = $urandom_range(99);
        for (int k = 0; k < total; k++) begin
            address_q = {address_q, (($urandom_range(1) == 1 && plen > 0) ?
                         pat_sel[$urandom_range(plen - 1)] : t_char'($urandom_range(255)))};
        end
        if (r < 70 && plen > 0 && total >= plen) begin
            case (mode_sel)
                amp_pkg::MODE_SUFFIX: pos = total - plen;
                amp_pkg::MODE_PREFIX: pos = (total > plen) ? 1 : 0;
                default:              pos = $urandom_range(total - plen);
            endcase
            for (int k = 0; k < plen; k++) address_q[pos+k] = pat_sel[k];
            if (r < 15) address_q[pos + $urandom_range(plen - 1)] ^= t_char'(1 << $urandom_range(7));
        end
    endtask

    initial begin
        int setup;
        int sent;
        int r;
        bit small_alphabet;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Out of reset: suffix mode, one character, all zero.
        address_q = {8'h00};
        send_address();
        settle();

        foreach (pat_sel[j]) pat_sel[j] = 8'h00;
        pat_sel[0] = 8'h41;
        pat_sel[1] = 8'h00;
        pat_sel[2] = 8'hFF;
        load_pattern(amp_pkg::MODE_SUFFIX, 3);
        // writes to unknown indexes must leave the pattern alone
        for (int idx = CFG_UNUSED_LO; idx <= CFG_UNUSED_HI; idx++) begin
            write_reg(amp_pkg::CFG_ADDR_W'(idx), '1);
        end
        address_q = {8'h10, 8'h41, 8'h00, 8'hFF};
        send_address();
        address_q = {8'h00, 8'hFF};              // shorter than the pattern
        send_address();
        settle();

        load_pattern(amp_pkg::MODE_PREFIX, 3);
        address_q = {8'h7A, 8'h41, 8'h00, 8'hFF};
        send_address();
        address_q = {8'h41, 8'h00, 8'hFF};       // not longer than the pattern
        send_address();
        settle();

        load_pattern(amp_pkg::MODE_CONTAINS, 3);
        address_q = {8'hFF, 8'h41, 8'h00, 8'hFF, 8'h00};
        send_address();
        settle();

        load_pattern(MODE_UNUSED, 3);            // the unused mode never matches
        address_q = {8'h41, 8'h00, 8'hFF};
        send_address();
        settle();

        load_pattern(amp_pkg::MODE_SUFFIX, 0);   // zero length never matches
        address_q = {8'h00};
        send_address();
        settle();

        // Random part: four pressure mixes, a few pattern setups in each.
        for (int mix = 0; mix < PRESSURE_MIXES; mix++) begin
            case (mix)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            for (int s = 0; s < SETUPS_PER_MIX; s++) begin
                setup = mix * SETUPS_PER_MIX + s;
                small_alphabet = $urandom_range(1);
                foreach (pat_sel[j]) begin
                    pat_sel[j] = small_alphabet ? t_char'(8'h30 + $urandom_range(1))
                                                : t_char'($urandom_range(255));
                end
                settle();
                case (setup)
                    3:  load_pattern(amp_pkg::MODE_CONTAINS, 31);   // long pattern, saturates
                    7:  load_pattern(amp_pkg::MODE_PREFIX, amp_pkg::MAX_PATTERN);
                    10: load_pattern(amp_pkg::MODE_SUFFIX, $urandom_range(21, 30));
                    11: load_pattern(MODE_UNUSED, $urandom_range(1, 8));
                    default: begin
                        r = $urandom_range(99);
                        load_pattern(($urandom_range(9) == 0) ? MODE_UNUSED
                                                              : 2'($urandom_range(2)),
                                     (r < 8) ? 0 : (r < 16) ? amp_pkg::MAX_PATTERN
                                                            : $urandom_range(1, 8));
                    end
                endcase
                sent = 0;
                while (sent < ITEMS_PER_SETUP) begin
                    make_address(setup == 5 && sent == 0);
                    send_address();
                    sent += address_q.size();
                end
            end
        end

        settle();
        $display("Covered %0d characters in %0d addresses over %0d pattern setups,",
                 items_sent, addresses_sent, setups_loaded);
        $display("all four modes and four stream pressure mixes; %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/amp_pkg.sv
src/amp_cfg_regs.sv
src/amp_core.sv
src/address_pattern_matcher_top.sv
src/amp_checker.sv
sim/address_pattern_checker.sv
sim/tb_top.sv
